FILE: rtl/vdi_pkg.sv
// ----------------------------------------------------------------------------
// vdi_pkg
// shared sizes for the vertex dedup indexer: table depth, address and
// count widths, vertex word layout
// ----------------------------------------------------------------------------
package vdi_pkg;

	localparam int MAX_UNIQUE = 1024;
	localparam int ADDR_W     = $clog2(MAX_UNIQUE);
	localparam int CNT_W      = $clog2(MAX_UNIQUE + 1);
	localparam int WORD_W     = 32;
	localparam int VTX_WORDS  = 8;
	localparam int VTX_W      = WORD_W * VTX_WORDS;
	localparam int IDX_W      = 10;

	typedef logic [VTX_W-1:0]  vtx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

endpackage

FILE: rtl/vdi_ram.sv
// ----------------------------------------------------------------------------
// vdi_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module vdi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/vdi_cmp.sv
// ----------------------------------------------------------------------------
// vdi_cmp
// vertex compare unit: float equality on all eight words
// ----------------------------------------------------------------------------
module vdi_cmp (
	input  vdi_pkg::vtx_t a,
	input  vdi_pkg::vtx_t b,
	output logic          match
);

	function automatic logic is_nan(input logic [vdi_pkg::WORD_W-1:0] w);
		return w[vdi_pkg::WORD_W-2:0] > 31'h7F80_0000;
	endfunction

	function automatic logic float_eq(input logic [vdi_pkg::WORD_W-1:0] x,
					  input logic [vdi_pkg::WORD_W-1:0] y);
		logic [vdi_pkg::WORD_W-1:0] o;
		o = x | y;
		if (is_nan(x) || is_nan(y)) begin
			return 1'b0;
		end
		return (x == y) || (o[vdi_pkg::WORD_W-2:0] == '0);
	endfunction

	logic [vdi_pkg::VTX_WORDS-1:0] word_eq;

	always_comb begin
		for (int k = 0; k < vdi_pkg::VTX_WORDS; k++) begin
			word_eq[k] = float_eq(a[k*vdi_pkg::WORD_W +: vdi_pkg::WORD_W],
					      b[k*vdi_pkg::WORD_W +: vdi_pkg::WORD_W]);
		end
	end

	assign match = &word_eq;

endmodule

FILE: rtl/vertex_dedup_indexer.sv
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// linear search of stored unique vertices, append on miss
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    start_mesh, pos_*, tex_*, color_*
//   out      output     out_valid/out_stall  vertex_index, is_new, table_full
//
// a hit stops at the matching entry, a miss reads every stored entry, an
// empty table skips the search; no new item is accepted until the last one
// resolves; the table memory has one read port, one entry per cycle
// reset clears the count and the control; table contents need no clearing
// a stalled result waits in the output register while the next item searches
// ----------------------------------------------------------------------------
module vertex_dedup_indexer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      start_mesh,
	input  logic [31:0]               pos_x,
	input  logic [31:0]               pos_y,
	input  logic [31:0]               pos_z,
	input  logic [31:0]               tex_u,
	input  logic [31:0]               tex_v,
	input  logic [31:0]               color_r,
	input  logic [31:0]               color_g,
	input  logic [31:0]               color_b,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [vdi_pkg::IDX_W-1:0] vertex_index,
	output logic                      is_new,
	output logic                      table_full
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_SEARCH  = 2'd1;
	localparam logic [1:0] ST_RESOLVE = 2'd2;

	logic [1:0]     state_q;
	vdi_pkg::vtx_t  vtx_q;
	vdi_pkg::cnt_t  cnt_q;
	vdi_pkg::cnt_t  rd_ptr_q;
	logic           chk_vld_s1;
	vdi_pkg::addr_t chk_idx_s1;
	logic           hit_q;
	vdi_pkg::addr_t hit_idx_q;
	logic           out_valid_q;
	logic [vdi_pkg::IDX_W-1:0] vertex_index_q;
	logic           is_new_q;
	logic           table_full_q;

	vdi_pkg::vtx_t  rdata;
	logic           match;
	logic           accept;
	logic           issue;
	logic           found;
	logic           last;
	logic           out_free;
	logic           res_load;
	logic           wr_en;
	vdi_pkg::cnt_t  cnt_start;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cnt_start = start_mesh ? '0 : cnt_q;
	assign issue     = (state_q == ST_SEARCH) && (rd_ptr_q < cnt_q);
	assign found     = chk_vld_s1 && match;
	assign last      = chk_vld_s1 &&
			   ((vdi_pkg::CNT_W'(chk_idx_s1) + vdi_pkg::CNT_W'(1)) == cnt_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign res_load  = (state_q == ST_RESOLVE) && out_free;
	assign wr_en     = res_load && !hit_q &&
			   (cnt_q < vdi_pkg::CNT_W'(vdi_pkg::MAX_UNIQUE));

	vdi_ram #(
		.WIDTH (vdi_pkg::VTX_W),
		.DEPTH (vdi_pkg::MAX_UNIQUE)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[vdi_pkg::ADDR_W-1:0]),
		.wdata (vtx_q),
		.re    (issue),
		.raddr (rd_ptr_q[vdi_pkg::ADDR_W-1:0]),
		.rdata (rdata)
	);

	vdi_cmp u_cmp (
		.a     (rdata),
		.b     (vtx_q),
		.match (match)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			vtx_q <= {color_b, color_g, color_r, tex_v, tex_u, pos_z, pos_y, pos_x};
		end
		if (issue) begin
			chk_idx_s1 <= rd_ptr_q[vdi_pkg::ADDR_W-1:0];
		end
		if (found) begin
			hit_idx_q <= chk_idx_s1;
		end
		if (res_load) begin
			if (hit_q) begin
				vertex_index_q <= vdi_pkg::IDX_W'(hit_idx_q);
				is_new_q       <= 1'b0;
				table_full_q   <= 1'b0;
			end else if (wr_en) begin
				vertex_index_q <= vdi_pkg::IDX_W'(cnt_q[vdi_pkg::ADDR_W-1:0]);
				is_new_q       <= 1'b1;
				table_full_q   <= 1'b0;
			end else begin
				vertex_index_q <= '0;
				is_new_q       <= 1'b0;
				table_full_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_ptr_q    <= '0;
			chk_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !res_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					chk_vld_s1 <= 1'b0;
					if (accept) begin
						cnt_q    <= cnt_start;
						rd_ptr_q <= '0;
						hit_q    <= 1'b0;
						state_q  <= (cnt_start == '0) ? ST_RESOLVE : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (found) begin
						hit_q      <= 1'b1;
						chk_vld_s1 <= 1'b0;
						state_q    <= ST_RESOLVE;
					end else if (last) begin
						chk_vld_s1 <= 1'b0;
						state_q    <= ST_RESOLVE;
					end else begin
						chk_vld_s1 <= issue;
						if (issue) begin
							rd_ptr_q <= rd_ptr_q + vdi_pkg::CNT_W'(1);
						end
					end
				end
				ST_RESOLVE: begin
					chk_vld_s1 <= 1'b0;
					if (res_load) begin
						out_valid_q <= 1'b1;
						if (wr_en) begin
							cnt_q <= cnt_q + vdi_pkg::CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					chk_vld_s1 <= 1'b0;
					state_q    <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign vertex_index = vertex_index_q;
	assign is_new       = is_new_q;
	assign table_full   = table_full_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= vdi_pkg::CNT_W'(vdi_pkg::MAX_UNIQUE))
		else $error("unique count beyond table depth");

	a_chk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (vdi_pkg::CNT_W'(chk_idx_s1) < cnt_q))
		else $error("compare on an entry that was never stored");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (cnt_q == $past(cnt_q) + vdi_pkg::CNT_W'(1)) && out_valid_q && is_new_q)
		else $error("append did not advance the count");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && table_full_q) |-> (vertex_index_q == '0) && !is_new_q)
		else $error("full result with index or new flag");

endmodule
